// File: hw/rtl/cmf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cmf_pkg;

  typedef struct packed {
    logic [6:0] cmd_byte;
    logic [7:0] cmd_length;
    logic       last;
  } cmd_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       run_last;
    logic       frame_end;
  } res_t;

  // One command character as handed from front to back.
  typedef struct packed {
    logic [6:0] cmd_byte;
    logic [7:0] frame_len;
    logic [7:0] dest;
    logic       last;
    logic       first;
  } q_entry_t;

  typedef enum logic [2:0] {
    ST_START,
    ST_HEAD,
    ST_CHAR,
    ST_BAR,
    ST_SUM,
    ST_CLOSE
  } cmf_state_e;

  localparam logic [7:0] LenExtra  = 8'd19;
  localparam logic [3:0] HeadLast  = 4'd12;
  localparam logic [3:0] SumLast   = 4'd3;

  localparam logic [7:0] ChLbrace  = 8'h7B;
  localparam logic [7:0] ChRbrace  = 8'h7D;
  localparam logic [7:0] ChF       = 8'h46;
  localparam logic [7:0] ChB       = 8'h42;
  localparam logic [7:0] ChSemi    = 8'h3B;
  localparam logic [7:0] ChBar     = 8'h7C;
  localparam logic [7:0] ChSix     = 8'h36;
  localparam logic [7:0] ChFour    = 8'h34;
  localparam logic [7:0] ChColon   = 8'h3A;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChUpperA  = 8'h41;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    if (v < 4'd10) begin
      return ChZero + {4'd0, v};
    end
    return ChUpperA + {4'd0, v} - 8'd10;
  endfunction

  function automatic logic [7:0] head_char(input logic [3:0] idx, input logic [7:0] dest,
                                           input logic [7:0] flen);
    logic [7:0] c;
    case (idx)
      4'd0:    c = ChLbrace;
      4'd1:    c = ChF;
      4'd2:    c = ChB;
      4'd3:    c = ChSemi;
      4'd4:    c = hex_digit(dest[7:4]);
      4'd5:    c = hex_digit(dest[3:0]);
      4'd6:    c = ChSemi;
      4'd7:    c = hex_digit(flen[7:4]);
      4'd8:    c = hex_digit(flen[3:0]);
      4'd9:    c = ChBar;
      4'd10:   c = ChSix;
      4'd11:   c = ChFour;
      default: c = ChColon;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/cmf_front.sv
`timescale 1ns / 1ps
`default_nettype none

module cmf_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [7:0]        cfg_wdata_i,
  input  wire logic              push,
  input  wire cmf_pkg::cmd_in_t  cmd_i,
  input  wire logic              q_full_i,
  output logic                   full,
  output logic                   q_wr_o,
  output cmf_pkg::q_entry_t      q_data_o
);

  logic       in_frame_q, in_frame_d;
  logic [7:0] dest_q;
  logic       accept;

  assign full   = q_full_i;
  assign accept = push && !q_full_i;
  assign q_wr_o = accept;

  always_comb begin
    q_data_o.cmd_byte  = cmd_i.cmd_byte;
    q_data_o.frame_len = cmd_i.cmd_length + cmf_pkg::LenExtra;
    q_data_o.dest      = dest_q;
    q_data_o.last      = cmd_i.last;
    q_data_o.first     = !in_frame_q;
  end

  always_comb begin
    in_frame_d = in_frame_q;
    if (accept) begin
      in_frame_d = !cmd_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      dest_q     <= 8'd1;
    end else begin
      in_frame_q <= in_frame_d;
      if (cfg_we_i) begin
        dest_q <= cfg_wdata_i;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/cmf_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module cmf_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               wr_i,
  input  wire cmf_pkg::q_entry_t  wr_data_i,
  output logic                    full_o,
  input  wire logic               rd_i,
  output logic                    valid_o,
  output cmf_pkg::q_entry_t       rd_data_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmf_pkg::q_entry_t entries_q [DEPTH];
  logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]     cnt_q;
  logic              do_wr, do_rd;

  assign full_o    = (cnt_q == CW'(DEPTH));
  assign valid_o   = (cnt_q != '0);
  assign rd_data_o = entries_q[rd_ptr_q];
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && valid_o;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    if (p == PW'(DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      entries_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_rd) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_no_wr_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i |-> !full_o)
    else $error("write into full queue");

endmodule

`default_nettype wire

// File: hw/rtl/cmf_back.sv
`timescale 1ns / 1ps
`default_nettype none

module cmf_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               q_valid_i,
  input  wire cmf_pkg::q_entry_t  q_data_i,
  output logic                    q_rd_o,
  output logic                    empty,
  input  wire logic               pop,
  output cmf_pkg::res_t           res_o
);

  cmf_pkg::cmf_state_e st_q, st_d, cur;
  logic [3:0]          cnt_q, cnt_d;
  logic [15:0]         sum_q, sum_d;
  logic                out_valid_q;
  cmf_pkg::res_t       out_q, gen;
  logic                step;

  assign empty = !out_valid_q;
  assign res_o = out_q;
  assign step  = q_valid_i && (!out_valid_q || pop);

  always_comb begin
    cur = st_q;
    if (st_q == cmf_pkg::ST_START) begin
      cur = q_data_i.first ? cmf_pkg::ST_HEAD : cmf_pkg::ST_CHAR;
    end
  end

  // next state
  always_comb begin
    st_d   = st_q;
    cnt_d  = cnt_q;
    q_rd_o = 1'b0;
    if (step) begin
      case (cur)
        cmf_pkg::ST_HEAD: begin
          if (cnt_q == cmf_pkg::HeadLast) begin
            st_d  = cmf_pkg::ST_CHAR;
            cnt_d = '0;
          end else begin
            st_d  = cmf_pkg::ST_HEAD;
            cnt_d = cnt_q + 1'b1;
          end
        end
        cmf_pkg::ST_CHAR: begin
          if (q_data_i.last) begin
            st_d = cmf_pkg::ST_BAR;
          end else begin
            st_d   = cmf_pkg::ST_START;
            q_rd_o = 1'b1;
          end
        end
        cmf_pkg::ST_BAR: begin
          st_d  = cmf_pkg::ST_SUM;
          cnt_d = '0;
        end
        cmf_pkg::ST_SUM: begin
          if (cnt_q == cmf_pkg::SumLast) begin
            st_d  = cmf_pkg::ST_CLOSE;
            cnt_d = '0;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
        cmf_pkg::ST_CLOSE: begin
          st_d   = cmf_pkg::ST_START;
          q_rd_o = 1'b1;
        end
        default: begin
          st_d = cmf_pkg::ST_START;
        end
      endcase
    end
  end

  // outputs and checksum
  always_comb begin
    gen.out_char  = cmf_pkg::ChColon;
    gen.run_last  = 1'b0;
    gen.frame_end = 1'b0;
    sum_d         = sum_q;
    case (cur)
      cmf_pkg::ST_HEAD: begin
        gen.out_char = cmf_pkg::head_char(cnt_q, q_data_i.dest, q_data_i.frame_len);
        sum_d = (cnt_q == '0) ? '0 : sum_q + {8'd0, gen.out_char};
      end
      cmf_pkg::ST_CHAR: begin
        gen.out_char = {1'b0, q_data_i.cmd_byte};
        gen.run_last = !q_data_i.last;
        sum_d        = sum_q + {9'd0, q_data_i.cmd_byte};
      end
      cmf_pkg::ST_BAR: begin
        gen.out_char = cmf_pkg::ChBar;
        sum_d        = sum_q + {8'd0, cmf_pkg::ChBar};
      end
      cmf_pkg::ST_SUM: begin
        case (cnt_q[1:0])
          2'd0:    gen.out_char = cmf_pkg::hex_digit(sum_q[15:12]);
          2'd1:    gen.out_char = cmf_pkg::hex_digit(sum_q[11:8]);
          2'd2:    gen.out_char = cmf_pkg::hex_digit(sum_q[7:4]);
          default: gen.out_char = cmf_pkg::hex_digit(sum_q[3:0]);
        endcase
      end
      cmf_pkg::ST_CLOSE: begin
        gen.out_char  = cmf_pkg::ChRbrace;
        gen.run_last  = 1'b1;
        gen.frame_end = 1'b1;
        sum_d         = '0;
      end
      default: begin
        sum_d = sum_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= gen;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= cmf_pkg::ST_START;
      cnt_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
      if (step) begin
        sum_q       <= sum_d;
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  a_end_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.frame_end |-> out_q.run_last)
    else $error("frame end without run_last");

  a_mid_entry : assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != cmf_pkg::ST_START |-> q_valid_i)
    else $error("entry left queue while still in use");

  a_rd_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_rd_o |=> st_q == cmf_pkg::ST_START && out_valid_q && out_q.run_last)
    else $error("entry retired without its final beat");

endmodule

`default_nettype wire

// File: hw/rtl/inverter_command_framer.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Handshake        | Payload
// ---------+------------------+-------------------------------
// command  | push / full      | cmd_i  (cmd_byte, cmd_length, last)
// result   | empty / pop      | res_o  (out_char, run_last, frame_end)
// config   | cfg_we_i         | cfg_wdata_i (dest_address)
//
// One result beat per cycle unless pop stalls or the queue is empty.
// The first character of a frame adds 13 header beats, the last adds 6.
// The back-end sequencer emitting one beat per cycle sets the rate;
// QUEUE_DEPTH command beats are buffered while it works through a burst.
// Async active-low reset: address 01, no frame open, queue empty.

module inverter_command_framer #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [7:0]        cfg_wdata_i,
  input  wire logic              push,
  output logic                   full,
  input  wire cmf_pkg::cmd_in_t  cmd_i,
  output logic                   empty,
  input  wire logic              pop,
  output cmf_pkg::res_t          res_o
);

  logic              q_wr, q_full, q_rd, q_valid;
  cmf_pkg::q_entry_t q_wdata, q_rdata;

  cmf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .push       (push),
    .cmd_i      (cmd_i),
    .q_full_i   (q_full),
    .full       (full),
    .q_wr_o     (q_wr),
    .q_data_o   (q_wdata)
  );

  cmf_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (q_wr),
    .wr_data_i(q_wdata),
    .full_o   (q_full),
    .rd_i     (q_rd),
    .valid_o  (q_valid),
    .rd_data_o(q_rdata)
  );

  cmf_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_valid_i(q_valid),
    .q_data_i (q_rdata),
    .q_rd_o   (q_rd),
    .empty    (empty),
    .pop      (pop),
    .res_o    (res_o)
  );

endmodule

`default_nettype wire
